@@ sv/json_string_escaper_assert.svh @@
// assertion macros for the json string escaper
// no dependencies; included by the top level
`ifndef JSON_STRING_ESCAPER_ASSERT_SVH
`define JSON_STRING_ESCAPER_ASSERT_SVH

`ifndef ASSERT_OFF
// property holds at every clock edge outside reset
`define JSE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define JSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define JSE_ASSERT(lbl, clk, rstn, prop, msg)
`define JSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ sv/jse_pkg.sv @@
// shared types, constants and helpers for the json string escaper
// no dependencies
package jse_pkg;

    localparam int HOLD_DEPTH = 5;
    localparam int ESC_MAX    = 6;

    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CHAR_U      = 8'h75;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [7:0] CHAR_DEL    = 8'h7F;
    localparam logic [7:0] UTF8_MASK   = 8'hC0;
    localparam logic [7:0] UTF8_CONT   = 8'h80;
    localparam logic [7:0] UTF8_LEAD3  = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4  = 8'hF0;

    localparam logic [15:0] CAP_MIN   = 16'd3;
    localparam logic [15:0] CAP_RESET = 16'd256;

    // register index decoded from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef logic [2:0] hcnt_t;
    typedef logic [2:0] ecnt_t;
    typedef logic [4:0] pos_t;
    typedef logic [HOLD_DEPTH-1:0][7:0] hold_arr_t;
    typedef logic [ESC_MAX-1:0][7:0]    esc_arr_t;

    // everything one input word sends, in output order
    typedef struct packed {
        logic      open;
        hold_arr_t rel;
        hcnt_t     rel_cnt;
        esc_arr_t  pay;
        ecnt_t     pay_cnt;
        hold_arr_t tail;
        hcnt_t     tail_cnt;
        logic      close;
    } job_t;

    typedef struct packed {
        logic  started;
        logic  stopped;
        hcnt_t held_cnt;
    } str_status_t;

    typedef struct packed {
        logic free;
        logic busy;
    } ser_status_t;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
        begin
            r = 8'h30 + {4'h0, v};
        end
        else
        begin
            r = 8'h57 + {4'h0, v};
        end
        return r;
    endfunction

endpackage

@@ sv/jse_front.sv @@
// string state and per-word escape decision for the json string escaper
// depends on jse_pkg
module jse_front
    import jse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic        has_byte,
    input  logic        end_of_string,
    input  logic [15:0] capacity,
    output job_t        job,
    output logic        job_nonempty,
    output str_status_t status
);

    logic        started_reg, started_next;
    logic        stopped_reg, stopped_next;
    logic [15:0] emitted_reg, emitted_next;
    hcnt_t       held_cnt_reg, held_cnt_next;
    hold_arr_t   held_reg, held_next;

    logic [15:0] cap_eff;
    logic [15:0] em0;
    esc_arr_t    esc;
    ecnt_t       el;
    logic [16:0] fit_sum;
    logic        fits;
    logic        is_cont;
    hcnt_t       need;
    logic        keep;
    job_t        job_c;

    always_comb
    begin
        esc = '0;
        esc[0] = in_byte;
        el = 3'd1;
        if (in_byte == CHAR_QUOTE || in_byte == CHAR_BSLASH)
        begin
            esc[0] = CHAR_BSLASH;
            esc[1] = in_byte;
            el = 3'd2;
        end
        else if (in_byte == CHAR_LF)
        begin
            esc[0] = CHAR_BSLASH;
            esc[1] = CHAR_N;
            el = 3'd2;
        end
        else if (in_byte == CHAR_TAB)
        begin
            esc[0] = CHAR_BSLASH;
            esc[1] = CHAR_T;
            el = 3'd2;
        end
        else if (in_byte < CTRL_LIMIT || in_byte == CHAR_DEL)
        begin
            esc[0] = CHAR_BSLASH;
            esc[1] = CHAR_U;
            esc[2] = CHAR_ZERO;
            esc[3] = CHAR_ZERO;
            esc[4] = hex_char(in_byte[7:4]);
            esc[5] = hex_char(in_byte[3:0]);
            el = 3'd6;
        end
    end

    assign cap_eff = (capacity < CAP_MIN) ? CAP_MIN : capacity;
    assign em0     = started_reg ? emitted_reg : 16'd1;
    assign fit_sum = {1'b0, em0} + {14'b0, el} + 17'd2;
    assign fits    = fit_sum <= {1'b0, cap_eff};
    assign is_cont = (in_byte & UTF8_MASK) == UTF8_CONT;

    always_comb
    begin
        job_c         = '0;
        job_c.open    = !started_reg;
        job_c.pay     = esc;
        job_c.close   = end_of_string;
        stopped_next  = started_reg ? stopped_reg : 1'b0;
        emitted_next  = em0;
        held_cnt_next = held_cnt_reg;
        held_next     = held_reg;

        if (has_byte && !stopped_next)
        begin
            if (!fits)
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                emitted_next = em0 + {13'b0, el};
                if (is_cont)
                begin
                    if (held_cnt_reg != 3'd0 && held_cnt_reg < hcnt_t'(HOLD_DEPTH))
                    begin
                        held_next[held_cnt_reg] = in_byte;
                        held_cnt_next = held_cnt_reg + 3'd1;
                    end
                    else
                    begin
                        job_c.rel     = held_reg;
                        job_c.rel_cnt = held_cnt_reg;
                        job_c.pay_cnt = 3'd1;
                        held_cnt_next = 3'd0;
                    end
                end
                else if (in_byte >= UTF8_MASK)
                begin
                    job_c.rel     = held_reg;
                    job_c.rel_cnt = held_cnt_reg;
                    held_next[0]  = in_byte;
                    held_cnt_next = 3'd1;
                end
                else
                begin
                    job_c.rel     = held_reg;
                    job_c.rel_cnt = held_cnt_reg;
                    job_c.pay_cnt = el;
                    held_cnt_next = 3'd0;
                end
            end
        end

        // trailing group is kept only when complete or a lone lead
        job_c.tail = held_next;
        if (end_of_string && keep)
        begin
            job_c.tail_cnt = held_cnt_next;
        end
    end

    assign need = (held_next[0] >= UTF8_LEAD4) ? 3'd3 :
                  (held_next[0] >= UTF8_LEAD3) ? 3'd2 : 3'd1;
    assign keep = (held_cnt_next == 3'd1) || (need == held_cnt_next - 3'd1);

    assign job = job_c;
    assign job_nonempty = job_c.open || job_c.close ||
                          (job_c.rel_cnt != 3'd0) || (job_c.pay_cnt != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            stopped_reg  <= 1'b0;
            emitted_reg  <= '0;
            held_cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (end_of_string)
            begin
                started_reg  <= 1'b0;
                stopped_reg  <= 1'b0;
                emitted_reg  <= '0;
                held_cnt_reg <= '0;
            end
            else
            begin
                started_reg  <= 1'b1;
                stopped_reg  <= stopped_next;
                emitted_reg  <= emitted_next;
                held_cnt_reg <= held_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

    assign status.started  = started_reg;
    assign status.stopped  = stopped_reg;
    assign status.held_cnt = held_cnt_reg;

endmodule

@@ sv/jse_ser.sv @@
// job register and output register: sends one job byte per cycle unless stalled
// depends on jse_pkg
module jse_ser
    import jse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  job_t        job_in,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        last,
    output ser_status_t status
);

    job_t       job_reg;
    logic       job_valid_reg, job_valid_next;
    pos_t       idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       last_reg;

    pos_t       b1, b2, b3, b4, total;
    pos_t       d1, d2, d3;
    logic [7:0] sel_byte;
    logic       sel_last;
    logic       adv;
    logic       done;

    // segment boundaries: open quote, released group, payload, kept tail, close quote
    assign b1    = {4'b0, job_reg.open};
    assign b2    = b1 + {2'b0, job_reg.rel_cnt};
    assign b3    = b2 + {2'b0, job_reg.pay_cnt};
    assign b4    = b3 + {2'b0, job_reg.tail_cnt};
    assign total = b4 + {4'b0, job_reg.close};
    assign d1    = idx_reg - b1;
    assign d2    = idx_reg - b2;
    assign d3    = idx_reg - b3;

    always_comb
    begin
        sel_last = 1'b0;
        if (idx_reg < b1)
        begin
            sel_byte = CHAR_QUOTE;
        end
        else if (idx_reg < b2)
        begin
            sel_byte = job_reg.rel[d1[2:0]];
        end
        else if (idx_reg < b3)
        begin
            sel_byte = job_reg.pay[d2[2:0]];
        end
        else if (idx_reg < b4)
        begin
            sel_byte = job_reg.tail[d3[2:0]];
        end
        else
        begin
            sel_byte = CHAR_QUOTE;
            sel_last = 1'b1;
        end
    end

    assign adv  = job_valid_reg && (!out_valid_reg || !out_stall);
    assign done = adv && (idx_reg == total - 5'd1);

    always_comb
    begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            job_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (done)
        begin
            job_valid_next = 1'b0;
        end
        else if (adv)
        begin
            idx_next = idx_reg + 5'd1;
        end

        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job_in;
        end
        if (adv)
        begin
            out_byte_reg <= sel_byte;
            last_reg     <= sel_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last        = last_reg;
    assign status.free = !job_valid_reg || done;
    assign status.busy = job_valid_reg;

endmodule

@@ sv/json_string_escaper.sv @@
// json string escaper: raw string bytes in, quoted and escaped json literal out
// top level; depends on jse_pkg, jse_front, jse_ser and json_string_escaper_assert.svh
//
// input words carry in_byte, has_byte and end_of_string on an in_valid/in_stall
// channel; output words carry out_byte and last on out_valid/out_stall, last
// marking the closing quote. capacity is to be written over the apb port only
// while idle, unchecked by the block. each accepted word is decoded into a job
// of up to 12 output bytes in the job register, which feeds the output register
// one byte per cycle while out_stall is low; a word's first byte passes the job
// register and then the output register. words that produce no bytes skip the
// job register. the next word is accepted in the cycle the last byte of the
// current job moves to the output register. utf-8 groups are held in the string
// state and released later; a partial group left at the end of a string is
// dropped. out_stall, while out_valid is high, freezes the output register and
// the job walk; in_stall rises once the job register cannot take a new job.
// reset empties both registers, clears the string state, sets capacity to 256.
`include "json_string_escaper_assert.svh"

module json_string_escaper
    import jse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        has_byte,
    input  logic        end_of_string,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last
);

    logic [15:0] capacity_reg;
    logic        cfg_wr;
    logic        accept;
    job_t        job;
    logic        job_nonempty;
    str_status_t str_st;
    ser_status_t ser_st;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? {16'b0, capacity_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr)
        begin
            capacity_reg <= pwdata[15:0];
        end
    end

    assign in_stall = !ser_st.free;
    assign accept   = in_valid && !in_stall;

    jse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_byte),
        .has_byte      (has_byte),
        .end_of_string (end_of_string),
        .capacity      (capacity_reg),
        .job           (job),
        .job_nonempty  (job_nonempty),
        .status        (str_st)
    );

    jse_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && job_nonempty),
        .job_in    (job),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .last      (last),
        .status    (ser_st)
    );

    `JSE_ASSERT(a_held_bound, clk, rst_n, str_st.held_cnt <= hcnt_t'(HOLD_DEPTH), "held group overflow")
    `JSE_ASSERT(a_stop_started, clk, rst_n, !str_st.stopped || str_st.started, "stopped outside a string")
    `JSE_ASSERT_NEXT(a_eos_clears, clk, rst_n, accept && end_of_string, !str_st.started && str_st.held_cnt == 3'd0, "string state not cleared at end")
    `JSE_ASSERT_NEXT(a_open_sets, clk, rst_n, accept && !end_of_string, str_st.started, "string not opened")
    `JSE_ASSERT_NEXT(a_load_busy, clk, rst_n, accept && job_nonempty, ser_st.busy, "job not loaded")

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking bench for json_string_escaper, with its own model of the escaping,
// utf-8 hold-back and truncation rules, random bursts, output stalls and capacity changes
// depends on jse_pkg and the json_string_escaper rtl

module tb_top;
    import jse_pkg::*;

    localparam int LIMIT_CYCLES    = 400000;
    localparam int WORDS_PER_PHASE = 34;
    localparam int NUM_PHASES      = 11;
    localparam int SETTLE_CYCLES   = 12;

    // {last, byte} of one literal byte
    typedef logic [8:0] lit_t;

    // one input word; typed rows carry their literal bytes, first byte in the top used byte
    typedef struct packed {
        logic [7:0]  b;
        logic        h;
        logic        e;
        logic        typed;
        logic [3:0]  n;
        logic [63:0] lit;
    } word_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        has_byte;
    logic        end_of_string;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        last;

    word_t directed_words[$];
    word_t pending_words[$];
    lit_t  literal_q[$];
    lit_t  escaped_bytes[$];

    // model state
    logic [15:0] capacity_reg;
    logic        str_open;
    logic        str_cut;
    int          lit_len;
    logic [7:0]  utf_held [HOLD_DEPTH];
    int          utf_cnt;

    int errors;
    int words_sent;
    int bytes_checked;
    int burst_left;
    int cycles;

    json_string_escaper uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .has_byte      (has_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic word_t mk_word(input logic [7:0] b, input logic h, input logic e,
                                      input logic typed, input int n, input logic [63:0] lit);
        word_t w;
        w.b     = b;
        w.h     = h;
        w.e     = e;
        w.typed = typed;
        w.n     = 4'(n);
        w.lit   = lit;
        return w;
    endfunction

    task automatic release_utf();
        for (int i = 0; i < utf_cnt; i++)
        begin
            escaped_bytes.push_back({1'b0, utf_held[i]});
        end
        utf_cnt = 0;
    endtask

    // literal bytes caused by one accepted word, left in escaped_bytes
    task automatic escape_word(input logic [7:0] b, input logic h, input logic e);
        int         cap_eff;
        int         n;
        int         need;
        logic [7:0] seq [ESC_MAX];
        escaped_bytes.delete();
        cap_eff = (capacity_reg < CAP_MIN) ? int'(CAP_MIN) : int'(capacity_reg);
        if (!str_open)
        begin
            escaped_bytes.push_back({1'b0, CHAR_QUOTE});
            str_open = 1'b1;
            lit_len  = 1;
        end
        if (h && !str_cut)
        begin
            n      = 2;
            seq[0] = CHAR_BSLASH;
            seq[1] = b;
            if (b == CHAR_LF)
            begin
                seq[1] = CHAR_N;
            end
            else if (b == CHAR_TAB)
            begin
                seq[1] = CHAR_T;
            end
            else if (b != CHAR_QUOTE && b != CHAR_BSLASH && (b < CTRL_LIMIT || b == CHAR_DEL))
            begin
                n      = 6;
                seq[1] = CHAR_U;
                seq[2] = CHAR_ZERO;
                seq[3] = CHAR_ZERO;
                seq[4] = (b[7:4] < 4'd10) ? CHAR_ZERO + {4'h0, b[7:4]}
                                          : 8'h61 + {4'h0, b[7:4]} - 8'd10;
                seq[5] = (b[3:0] < 4'd10) ? CHAR_ZERO + {4'h0, b[3:0]}
                                          : 8'h61 + {4'h0, b[3:0]} - 8'd10;
            end
            else if (b != CHAR_QUOTE && b != CHAR_BSLASH)
            begin
                n      = 1;
                seq[0] = b;
            end
            // room is kept for the closing quote and the terminator
            if (lit_len + n + 2 > cap_eff)
            begin
                str_cut = 1'b1;
            end
            else
            begin
                lit_len += n;
                if ((b & UTF8_MASK) == UTF8_CONT)
                begin
                    if (utf_cnt > 0 && utf_cnt < HOLD_DEPTH)
                    begin
                        utf_held[utf_cnt] = b;
                        utf_cnt++;
                    end
                    else
                    begin
                        release_utf();
                        escaped_bytes.push_back({1'b0, b});
                    end
                end
                else if (b >= UTF8_MASK)
                begin
                    release_utf();
                    utf_held[0] = b;
                    utf_cnt     = 1;
                end
                else
                begin
                    release_utf();
                    for (int i = 0; i < n; i++)
                    begin
                        escaped_bytes.push_back({1'b0, seq[i]});
                    end
                end
            end
        end
        if (e)
        begin
            if (utf_cnt > 0)
            begin
                need = (utf_held[0] >= UTF8_LEAD4) ? 3 : (utf_held[0] >= UTF8_LEAD3) ? 2 : 1;
                // a lone lead stays, a partial group goes
                if (utf_cnt == 1 || need == utf_cnt - 1)
                begin
                    release_utf();
                end
                else
                begin
                    utf_cnt = 0;
                end
            end
            escaped_bytes.push_back({1'b1, CHAR_QUOTE});
            str_open = 1'b0;
            str_cut  = 1'b0;
            lit_len  = 0;
            utf_cnt  = 0;
        end
    endtask

    task automatic send_word(input word_t w);
        int gap;
        int cnt;
        in_valid      <= 1'b1;
        in_byte       <= w.b;
        has_byte      <= w.h;
        end_of_string <= w.e;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        escape_word(w.b, w.h, w.e);
        if (w.typed)
        begin
            cnt = int'(w.n);
            for (int i = 0; i < cnt; i++)
            begin
                literal_q.push_back({w.e && (i == cnt - 1), w.lit[8 * (cnt - 1 - i) +: 8]});
            end
        end
        else
        begin
            foreach (escaped_bytes[i])
            begin
                literal_q.push_back(escaped_bytes[i]);
            end
        end
        words_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // appends one random piece of string content to pending_words
    task automatic add_piece();
        int         sel;
        int         cnt;
        logic [7:0] lead;
        sel = $urandom_range(0, 99);
        if (sel < 40)
        begin
            pending_words.push_back(mk_word(8'($urandom_range(32, 126)), 1'b1, 1'b0, 1'b0, 0, 0));
        end
        else if (sel < 52)
        begin
            case ($urandom_range(0, 3))
                0: lead = CHAR_QUOTE;
                1: lead = CHAR_BSLASH;
                2: lead = CHAR_LF;
                default: lead = CHAR_TAB;
            endcase
            pending_words.push_back(mk_word(lead, 1'b1, 1'b0, 1'b0, 0, 0));
        end
        else if (sel < 60)
        begin
            lead = 8'($urandom_range(0, 32));
            if (lead == CTRL_LIMIT)
            begin
                lead = CHAR_DEL;
            end
            pending_words.push_back(mk_word(lead, 1'b1, 1'b0, 1'b0, 0, 0));
        end
        else if (sel < 88)
        begin
            // well-formed groups first, then leads with a random number of continuations
            if (sel < 78)
            begin
                cnt  = $urandom_range(1, 3);
                lead = (cnt == 1) ? 8'($urandom_range(8'hc0, 8'hdf))
                     : (cnt == 2) ? 8'($urandom_range(8'he0, 8'hef))
                                  : 8'($urandom_range(8'hf0, 8'hff));
            end
            else
            begin
                cnt  = $urandom_range(0, 6);
                lead = 8'($urandom_range(8'hc0, 8'hff));
            end
            pending_words.push_back(mk_word(lead, 1'b1, 1'b0, 1'b0, 0, 0));
            repeat (cnt)
            begin
                pending_words.push_back(mk_word(8'($urandom_range(8'h80, 8'hbf)),
                                                1'b1, 1'b0, 1'b0, 0, 0));
            end
        end
        else if (sel < 93)
        begin
            pending_words.push_back(mk_word(8'($urandom_range(8'h80, 8'hbf)),
                                            1'b1, 1'b0, 1'b0, 0, 0));
        end
        else if (sel < 97)
        begin
            pending_words.push_back(mk_word(8'($urandom), 1'b1, 1'b0, 1'b0, 0, 0));
        end
        else
        begin
            pending_words.push_back(mk_word(8'($urandom), 1'b0, 1'b0, 1'b0, 0, 0));
        end
    endtask

    task automatic send_pending();
        foreach (pending_words[i])
        begin
            send_word(pending_words[i]);
        end
        pending_words.delete();
    endtask

    task automatic send_random_string();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 10);
        repeat (len) add_piece();
        pending_words.push_back(mk_word(8'($urandom), 1'($urandom_range(0, 1)), 1'b1,
                                        1'b0, 0, 0));
        send_pending();
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_capacity();
        logic [31:0] rd;
        apb_access(1'b0, 32'h0, rd);
        if (rd[15:0] !== capacity_reg)
        begin
            $display("%0t: capacity readback expected %0d actual %0d", $time, capacity_reg,
                     rd[15:0]);
            errors++;
        end
    endtask

    task automatic set_capacity(input logic [15:0] v);
        logic [31:0] rd;
        apb_access(1'b1, {16'($urandom), v}, rd);
        capacity_reg = v;
        check_capacity();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (literal_q.size() != 0)
        begin
            @(posedge clk);
        end
        // held utf-8 bytes produce nothing, so let the pipeline settle
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver stall pattern
    initial
    begin
        int mode;
        int mode_left;
        out_stall = 1'b0;
        mode      = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(4, 60);
            end
            mode_left--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 9) < 6);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // compare each accepted literal byte with the oldest expected one
    always @(posedge clk)
    begin
        lit_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            bytes_checked++;
            if (literal_q.size() == 0)
            begin
                $display("%0t: unexpected word byte %02h last %0b", $time, out_byte, last);
                errors++;
            end
            else
            begin
                want = literal_q.pop_front();
                if (out_byte !== want[7:0] || last !== want[8])
                begin
                    $display("%0t: out_byte expected %02h actual %02h, last expected %0b actual %0b",
                             $time, want[7:0], out_byte, want[8], last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("cycle limit hit with %0d literal bytes outstanding", literal_q.size());
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [15:0] cap_plan [NUM_PHASES];
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        in_byte       = '0;
        has_byte      = 1'b0;
        end_of_string = 1'b0;
        capacity_reg  = CAP_RESET;
        str_open      = 1'b0;
        str_cut       = 1'b0;
        lit_len       = 0;
        utf_cnt       = 0;
        errors        = 0;
        words_sent    = 0;
        bytes_checked = 0;
        burst_left    = 0;

        // escapes, control bytes, utf-8 holds and string edges at the reset capacity
        directed_words.push_back(mk_word(8'h41, 1'b1, 1'b0, 1'b1, 2, "\"A"));
        directed_words.push_back(mk_word(CHAR_QUOTE, 1'b1, 1'b0, 1'b1, 2, "\\\""));
        directed_words.push_back(mk_word(CHAR_BSLASH, 1'b1, 1'b0, 1'b1, 2, "\\\\"));
        directed_words.push_back(mk_word(CHAR_LF, 1'b1, 1'b0, 1'b1, 2, "\\n"));
        directed_words.push_back(mk_word(CHAR_TAB, 1'b1, 1'b0, 1'b1, 2, "\\t"));
        directed_words.push_back(mk_word(8'h00, 1'b1, 1'b0, 1'b1, 6, "\\u0000"));
        directed_words.push_back(mk_word(8'h1f, 1'b1, 1'b0, 1'b1, 6, "\\u001f"));
        directed_words.push_back(mk_word(CHAR_DEL, 1'b1, 1'b0, 1'b1, 6, "\\u007f"));
        directed_words.push_back(mk_word(8'hff, 1'b1, 1'b0, 1'b1, 0, 0));
        directed_words.push_back(mk_word(8'h80, 1'b1, 1'b0, 1'b1, 0, 0));
        directed_words.push_back(mk_word(8'h41, 1'b1, 1'b0, 1'b1, 3, {8'hff, 8'h80, 8'h41}));
        directed_words.push_back(mk_word(8'h80, 1'b1, 1'b0, 1'b1, 1, 64'h80));
        directed_words.push_back(mk_word(8'hc3, 1'b1, 1'b0, 1'b1, 0, 0));
        directed_words.push_back(mk_word(8'ha9, 1'b1, 1'b0, 1'b1, 0, 0));
        directed_words.push_back(mk_word(8'h00, 1'b0, 1'b1, 1'b1, 3,
                                         {8'hc3, 8'ha9, CHAR_QUOTE}));
        directed_words.push_back(mk_word(8'hff, 1'b0, 1'b0, 1'b1, 1, "\""));
        directed_words.push_back(mk_word(8'he2, 1'b1, 1'b0, 1'b1, 0, 0));
        directed_words.push_back(mk_word(8'h82, 1'b1, 1'b0, 1'b1, 0, 0));
        directed_words.push_back(mk_word(8'h00, 1'b0, 1'b1, 1'b1, 1, "\""));
        directed_words.push_back(mk_word(8'h55, 1'b0, 1'b1, 1'b1, 2, "\"\""));
        directed_words.push_back(mk_word(8'hf0, 1'b1, 1'b0, 1'b0, 0, 0));
        directed_words.push_back(mk_word(8'h90, 1'b1, 1'b0, 1'b0, 0, 0));
        directed_words.push_back(mk_word(8'h80, 1'b1, 1'b0, 1'b0, 0, 0));
        directed_words.push_back(mk_word(8'hbf, 1'b1, 1'b0, 1'b0, 0, 0));
        directed_words.push_back(mk_word(8'h80, 1'b1, 1'b0, 1'b0, 0, 0));
        directed_words.push_back(mk_word(8'h80, 1'b1, 1'b0, 1'b0, 0, 0));
        directed_words.push_back(mk_word(8'hc5, 1'b1, 1'b1, 1'b0, 0, 0));

        cap_plan = '{16'd0, 16'd2, CAP_MIN, 16'd4, 16'd9, 16'd16, 16'd30, 16'hffff,
                     16'($urandom_range(5, 80)), 16'($urandom), CAP_RESET};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_capacity();

        foreach (directed_words[i])
        begin
            send_word(directed_words[i]);
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_capacity(cap_plan[p]);
            while (words_sent < directed_words.size() + (p + 1) * WORDS_PER_PHASE)
            begin
                send_random_string();
            end
            // leave some strings open across the capacity change
            if ($urandom_range(0, 1) == 1)
            begin
                repeat ($urandom_range(1, 4)) add_piece();
                send_pending();
            end
            drain();
        end

        $display("%0d input words over %0d capacity settings, %0d literal bytes compared",
                 words_sent, NUM_PHASES + 1, bytes_checked);
        $display("%0d mismatches, %0d bytes still expected", errors, literal_q.size());
        if (errors == 0 && literal_q.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
